FILE: design/pnsf_pkg.sv
// ----------------------------------------------------------------------------
// pnsf_pkg
// Shared types, coefficient table and command/status structs for the pink
// noise shaping filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pnsf_pkg;

  // Width of the unsigned Q0.24 coefficients
  localparam int unsigned COEF_W = 24;

  // Number of one-pole lowpass sections
  localparam int unsigned NUM_POLES = 3;

  // Coefficient selector; member order follows the controller's product sequence
  typedef enum logic [2:0] {
    COEF_SLOW_POLE,
    COEF_SLOW_GAIN,
    COEF_MID_POLE,
    COEF_MID_GAIN,
    COEF_FAST_POLE,
    COEF_FAST_GAIN,
    COEF_WHITE_MIX,
    COEF_OUT_SCALE
  } coef_e;

  // Multiplier operand source
  typedef enum logic [1:0] {
    SRC_STATE,
    SRC_WHITE,
    SRC_ACC
  } src_e;

  // Pole state index
  typedef logic [1:0] slot_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  load_white;
    logic  mul_lo;
    logic  mul_hi;
    logic  rnd;
    logic  acc_clr;
    logic  out_rnd;
    src_e  src;
    coef_e coef;
    slot_t slot;
    logic  state_wr;
    logic  mix_sum;
    logic  out_ld;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } stat_t;

  // Q0.24 coefficient values (nearest integer to value * 2^24)
  function automatic logic [COEF_W-1:0] coef_value(input coef_e sel);
    logic [COEF_W-1:0] val;
    case (sel)
      COEF_SLOW_POLE: val = 24'd16758090;
      COEF_SLOW_GAIN: val = 24'd931436;
      COEF_MID_POLE:  val = 24'd16665144;
      COEF_MID_GAIN:  val = 24'd1259565;
      COEF_FAST_POLE: val = 24'd16257122;
      COEF_FAST_GAIN: val = 24'd2581208;
      COEF_WHITE_MIX: val = 24'd8995943;
      COEF_OUT_SCALE: val = 24'd8987135;
      default:        val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: design/pink_noise_shaping_filter_top.sv
// ----------------------------------------------------------------------------
// pink_noise_shaping_filter_top
// Three-pole pink noise shaping filter with stream input and output.
// ----------------------------------------------------------------------------
// Takes one signed Q1.(SAMPLE_WIDTH-1) white noise sample per transaction and
// returns one pink noise sample in the same format. A new input is taken only
// once the sequencer is back in idle, after the previous sample has been loaded
// into the output register. A single shared multiplier serves all arithmetic:
// eight coefficient products per sample, each split into a low and a high
// partial product plus a rounding step, followed by three state write-backs,
// one mix sum and one output load. The finished
// sample sits in an output register, so a stalled master side holds only the
// last result while the next sample is already being worked on. Pole states
// reset to zero and saturate at ACC_WIDTH bits; the output saturates at full
// scale.
`timescale 1ns / 1ps
`default_nettype none

module pink_noise_shaping_filter_top #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned ACC_WIDTH    = 32,
  localparam int unsigned TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [TDATA_W-1:0]  s_axis_tdata,   // [SAMPLE_WIDTH-1:0] white_sample
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [TDATA_W-1:0]  m_axis_tdata    // [SAMPLE_WIDTH-1:0] pink_sample
);

  pnsf_pkg::cmd_t          cmd;
  pnsf_pkg::stat_t         stat;
  logic [SAMPLE_WIDTH-1:0] pink;

  pnsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pnsf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .white_i     (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .pink_o      (pink),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  // Pad the sample to whole bytes
  assign m_axis_tdata = TDATA_W'(pink);

endmodule

`default_nettype wire

FILE: design/pnsf_datapath.sv
// ----------------------------------------------------------------------------
// pnsf_datapath
// Shared multiplier with split partial products, rounding, accumulator,
// pole state registers and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnsf_datapath #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned ACC_WIDTH    = 32
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire  [SAMPLE_WIDTH-1:0]   white_i,
  input  wire  pnsf_pkg::cmd_t      cmd_i,
  output pnsf_pkg::stat_t           stat_o,
  output logic [SAMPLE_WIDTH-1:0]   pink_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i
);

  localparam int unsigned CW       = pnsf_pkg::COEF_W;
  localparam int unsigned OP_W     = ACC_WIDTH + 3;           // signed operand
  localparam int unsigned HI_W     = OP_W - CW;               // upper magnitude slice
  localparam int unsigned MUL_W    = (HI_W > CW) ? HI_W : CW; // multiplier operand
  localparam int unsigned PROD_W   = MUL_W + CW;
  localparam int unsigned LO_W     = 2 * CW;                  // low partial product
  localparam int unsigned PHI_W    = HI_W + CW;               // high partial product
  localparam int unsigned R_W      = ACC_WIDTH + 5;           // accumulator
  localparam int unsigned W_SHIFT  = 25 - SAMPLE_WIDTH;       // white to Q.24
  localparam int unsigned OUT_SH   = 49 - SAMPLE_WIDTH;       // output scale shift
  localparam int unsigned OUT_DROP = OUT_SH - CW;
  localparam int unsigned OUT_BIAS = OUT_SH - CW - 1;

  logic signed [SAMPLE_WIDTH-1:0] white_q;
  logic signed [ACC_WIDTH-1:0]    st_q [pnsf_pkg::NUM_POLES];
  logic signed [R_W-1:0]          acc_q;
  logic [LO_W-1:0]                plo_q;
  logic [PHI_W-1:0]               phi_q;
  logic                           neg_q;
  logic [SAMPLE_WIDTH-1:0]        pink_q;
  logic                           out_valid_q;

  logic signed [OP_W-1:0] w24;
  logic signed [OP_W-1:0] opnd;
  logic                   opnd_neg;
  logic [OP_W-1:0]        mag;
  logic [MUL_W-1:0]       mul_a;
  logic [CW-1:0]          coef;
  logic [PROD_W-1:0]      prod;
  logic [LO_W:0]          lo_bias;
  logic [R_W-2:0]         out_t;
  logic [R_W-2:0]         rnd_mag;
  logic signed [R_W-1:0]  rnd_ext;
  logic signed [R_W-1:0]  rnd_s;
  logic signed [R_W-1:0]  st_sum;
  logic [ACC_WIDTH-1:0]   st_sat;
  logic [SAMPLE_WIDTH-1:0] out_sat;
  logic                   st_ovf;
  logic                   out_ovf;
  logic                   out_free;

  // White sample aligned to Q.24
  assign w24 = {{(OP_W - SAMPLE_WIDTH){white_q[SAMPLE_WIDTH-1]}}, white_q} <<< W_SHIFT;

  // Operand select and sign-magnitude split
  always_comb begin
    case (cmd_i.src)
      pnsf_pkg::SRC_STATE: opnd = {{(OP_W - ACC_WIDTH){st_q[cmd_i.slot][ACC_WIDTH-1]}},
                                   st_q[cmd_i.slot]};
      pnsf_pkg::SRC_WHITE: opnd = w24;
      pnsf_pkg::SRC_ACC:   opnd = acc_q[OP_W-1:0];
      default:             opnd = '0;
    endcase
    opnd_neg = opnd[OP_W-1];
    mag      = opnd_neg ? -opnd : opnd;
  end

  // Shared multiplier: low 24 bits of magnitude first, upper slice next
  assign mul_a = cmd_i.mul_hi ? MUL_W'(mag[OP_W-1:CW]) : MUL_W'(mag[CW-1:0]);
  assign coef  = pnsf_pkg::coef_value(cmd_i.coef);
  assign prod  = PROD_W'(mul_a) * PROD_W'(coef);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      plo_q <= prod[LO_W-1:0];
      neg_q <= opnd_neg;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= prod[PHI_W-1:0];
    end
  end

  // Combine partial products, round half away from zero, restore sign
  always_comb begin
    lo_bias = {1'b0, plo_q} + ((LO_W + 1)'(1) << (CW - 1));
    out_t   = (R_W - 1)'(phi_q) + ((R_W - 1)'(1) << OUT_BIAS)
            + (R_W - 1)'(plo_q[LO_W-1:CW]);
    if (cmd_i.out_rnd) begin
      rnd_mag = out_t >> OUT_DROP;
    end else begin
      rnd_mag = (R_W - 1)'(phi_q) + (R_W - 1)'(lo_bias[LO_W:CW]);
    end
    rnd_ext = {1'b0, rnd_mag};
    rnd_s   = neg_q ? -rnd_ext : rnd_ext;
  end

  // Sum of the three pole states
  always_comb begin
    st_sum = '0;
    for (int i = 0; i < pnsf_pkg::NUM_POLES; i++) begin
      st_sum = st_sum + {{(R_W - ACC_WIDTH){st_q[i][ACC_WIDTH-1]}}, st_q[i]};
    end
  end

  // Accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd) begin
      acc_q <= (cmd_i.acc_clr ? '0 : acc_q) + rnd_s;
    end else if (cmd_i.mix_sum) begin
      acc_q <= acc_q + st_sum;
    end
  end

  // Saturation of accumulator to state and output widths
  always_comb begin
    st_ovf  = (acc_q[R_W-1:ACC_WIDTH-1] != '0) && (acc_q[R_W-1:ACC_WIDTH-1] != '1);
    out_ovf = (acc_q[R_W-1:SAMPLE_WIDTH-1] != '0)
           && (acc_q[R_W-1:SAMPLE_WIDTH-1] != '1);
    if (!st_ovf) begin
      st_sat = acc_q[ACC_WIDTH-1:0];
    end else if (acc_q[R_W-1]) begin
      st_sat = {1'b1, {(ACC_WIDTH - 1){1'b0}}};
    end else begin
      st_sat = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
    end
    if (!out_ovf) begin
      out_sat = acc_q[SAMPLE_WIDTH-1:0];
    end else if (acc_q[R_W-1]) begin
      out_sat = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    end
  end

  // Pole states, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pnsf_pkg::NUM_POLES; i++) begin
        st_q[i] <= '0;
      end
    end else if (cmd_i.state_wr) begin
      st_q[cmd_i.slot] <= st_sat;
    end
  end

  // Input sample capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_white) begin
      white_q <= white_i;
    end
  end

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld && out_free) begin
      pink_q <= out_sat;
    end
  end

  assign stat_o.out_free = out_free;
  assign pink_o          = pink_q;
  assign out_valid_o     = out_valid_q;

endmodule

`default_nettype wire

FILE: design/pnsf_ctrl.sv
// ----------------------------------------------------------------------------
// pnsf_ctrl
// Sequencer for the eight products per sample, state write-back, output
// mix sum and output load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnsf_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  pnsf_pkg::stat_t stat_i,
  output pnsf_pkg::cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_MUL_LO   = 7'b0000010,
    ST_MUL_HI   = 7'b0000100,
    ST_MUL_RND  = 7'b0001000,
    ST_STATE_WR = 7'b0010000,
    ST_MIX_SUM  = 7'b0100000,
    ST_OUT_LD   = 7'b1000000
  } state_e;

  // Product index: below 6, even = pole * state, odd = gain * white; 6 = white mix, 7 = scale
  localparam logic [2:0] OP_FIRST = 3'd0;
  localparam logic [2:0] OP_MIX   = 3'd6;
  localparam logic [2:0] OP_OUT   = 3'd7;

  state_e     state_q, state_d;
  logic [2:0] op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_FIRST;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;

    cmd_o            = '0;
    cmd_o.slot       = op_q[2:1];
    cmd_o.coef       = pnsf_pkg::coef_e'(op_q); // coefficient order follows op index
    cmd_o.acc_clr    = !op_q[0] || (op_q == OP_OUT);
    cmd_o.out_rnd    = (op_q == OP_OUT);
    if (op_q == OP_OUT) begin
      cmd_o.src = pnsf_pkg::SRC_ACC;
    end else if (op_q[0] || (op_q == OP_MIX)) begin
      cmd_o.src = pnsf_pkg::SRC_WHITE;
    end else begin
      cmd_o.src = pnsf_pkg::SRC_STATE;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_white = 1'b1;
          op_d             = OP_FIRST;
          state_d          = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_MUL_RND;
      end
      ST_MUL_RND: begin
        cmd_o.rnd = 1'b1;
        if (op_q == OP_OUT) begin
          state_d = ST_OUT_LD;
        end else if (op_q == OP_MIX) begin
          state_d = ST_MIX_SUM;
        end else if (op_q[0]) begin
          state_d = ST_STATE_WR;
        end else begin
          op_d    = op_q + 3'd1;
          state_d = ST_MUL_LO;
        end
      end
      ST_STATE_WR: begin
        cmd_o.state_wr = 1'b1;
        op_d           = op_q + 3'd1;
        state_d        = ST_MUL_LO;
      end
      ST_MIX_SUM: begin
        cmd_o.mix_sum = 1'b1;
        op_d          = op_q + 3'd1;
        state_d       = ST_MUL_LO;
      end
      ST_OUT_LD: begin
        cmd_o.out_ld = 1'b1;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Write-back only follows a gain product of a pole section
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STATE_WR) |-> (op_q[0] && (op_q != OP_OUT)))
    else $error("state write-back outside a pole section");

  // Mix sum only after the white mix product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX_SUM) |-> (op_q == OP_MIX))
    else $error("mix sum at wrong product index");

  // A loaded result returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT_LD && stat_i.out_free) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after output load");

  // One sample in flight: no acceptance right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a sample is in progress");

endmodule

`default_nettype wire

FILE: tb/pink_noise_shaping_filter_top_test.sv
// ----------------------------------------------------------------------------
// pink_noise_shaping_filter_top_test
// Self-checking bench for the three-pole pink noise shaping filter.
// ----------------------------------------------------------------------------
// White noise samples go in on the slave stream and every pink sample that
// comes out is compared with a bit-exact fixed-point model of the three pole
// states, the white mix and the output scaling. A short table covers reset,
// both rails and the saturating output. Random segments of uniform, near-rail
// and tiny samples follow. Both stream sides idle at random, and one long
// output stall backs the filter up into its input.
`timescale 1ns / 1ps

module pink_noise_shaping_filter_top_test;

  localparam int unsigned SW           = 16;
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned DRAIN_CYCLES = 40;

  // Q0.24 filter coefficients
  localparam longint unsigned K_SLOW_POLE = 64'd16758090;
  localparam longint unsigned K_SLOW_GAIN = 64'd931436;
  localparam longint unsigned K_MID_POLE  = 64'd16665144;
  localparam longint unsigned K_MID_GAIN  = 64'd1259565;
  localparam longint unsigned K_FAST_POLE = 64'd16257122;
  localparam longint unsigned K_FAST_GAIN = 64'd2581208;
  localparam longint unsigned K_WHITE_MIX = 64'd8995943;
  localparam longint unsigned K_OUT_SCALE = 64'd8987135;

  localparam logic [SW-1:0] PINK_MAX = 16'h7FFF;
  localparam logic [SW-1:0] PINK_MIN = 16'h8000;

  typedef struct packed {
    logic [SW-1:0] white;
    logic          fixed;   // pink value below is typed in, not predicted
    logic [SW-1:0] pink;
  } dir_row_t;

  // Reset zeros, a positive run into the upper rail, a negative run, bit patterns
  localparam int unsigned DIR_ROWS = 24;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{16'h0000, 1'b1, 16'h0000},
    '{16'h0000, 1'b1, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000},
    '{16'h7FFF, 1'b1, PINK_MAX},
    '{16'h7FFF, 1'b1, PINK_MAX},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h0001, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b0, 16'h0000},
    '{16'h5555, 1'b0, 16'h0000},
    '{16'hAAAA, 1'b0, 16'h0000}
  };

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [SW-1:0] s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [SW-1:0] m_axis_tdata;

  // Expected pink samples, oldest first
  logic [SW-1:0] pink_q [$];

  // Filter state of the model, Q8.24
  longint slow_st;
  longint mid_st;
  longint fast_st;

  int unsigned errors;
  int unsigned cycles;
  int unsigned sent;
  int unsigned checked;
  int unsigned rail_hi;
  int unsigned rail_lo;
  bit          quiet;       // no idling on either side
  bit          hold_req;    // asks the output side for one long stall

  pink_noise_shaping_filter_top #(
    .SAMPLE_WIDTH (SW),
    .ACC_WIDTH    (32)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // round(a * k / 2^sh), ties away from zero
  function automatic longint scale_round(longint a, longint unsigned k, int unsigned sh);
    longint unsigned mag;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned r;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    hi  = (mag >> 24) * k;
    lo  = (mag & 64'hFF_FFFF) * k;
    if (sh == 24) begin
      r = hi + ((lo + 64'h80_0000) >> 24);
    end else begin
      r = (hi + (64'd1 << (sh - 25)) + (lo >> 24)) >> (sh - 24);
    end
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_signed(longint v, int unsigned bits);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) << (bits - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) return hi_lim;
    if (v < lo_lim) return lo_lim;
    return v;
  endfunction

  // Advance the three poles by one white sample and return the pink sample
  function automatic logic [SW-1:0] predict_pink(logic [SW-1:0] white);
    longint w24;
    longint sum;
    longint y;
    w24     = longint'($signed(white)) * 512;
    slow_st = clamp_signed(scale_round(slow_st, K_SLOW_POLE, 24)
                           + scale_round(w24, K_SLOW_GAIN, 24), 32);
    mid_st  = clamp_signed(scale_round(mid_st, K_MID_POLE, 24)
                           + scale_round(w24, K_MID_GAIN, 24), 32);
    fast_st = clamp_signed(scale_round(fast_st, K_FAST_POLE, 24)
                           + scale_round(w24, K_FAST_GAIN, 24), 32);
    sum = slow_st + mid_st + fast_st + scale_round(w24, K_WHITE_MIX, 24);
    y   = clamp_signed(scale_round(sum, K_OUT_SCALE, 33), SW);
    return y[SW-1:0];
  endfunction

  function automatic int unsigned idle_cycles();
    if (quiet) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output check: every result transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pink_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected pink sample, expected none, actual %h",
                 $time, m_axis_tdata);
      end else begin
        logic [SW-1:0] want;
        want = pink_q.pop_front();
        checked = checked + 1;
        if (m_axis_tdata !== want) begin
          errors = errors + 1;
          $display("%0t: pink_sample mismatch, expected %h, actual %h",
                   $time, want, m_axis_tdata);
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      gap = idle_cycles();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // One input transaction; the model runs when it is accepted
  task automatic send_white(input logic [SW-1:0] white, input bit fixed,
                            input logic [SW-1:0] pink);
    int unsigned   gap;
    logic [SW-1:0] want;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= white;
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_pink(white);
    if (fixed) want = pink;
    if (want == PINK_MAX) rail_hi = rail_hi + 1;
    if (want == PINK_MIN) rail_lo = rail_lo + 1;
    pink_q.push_back(want);
    sent = sent + 1;
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    int unsigned   kind;
    int unsigned   len;
    int unsigned   done;
    logic [SW-1:0] white;
    errors        = 0;
    cycles        = 0;
    sent          = 0;
    checked       = 0;
    rail_hi       = 0;
    rail_lo       = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    slow_st       = 0;
    mid_st        = 0;
    fast_st       = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_white(DIRECTED[i].white, DIRECTED[i].fixed, DIRECTED[i].pink);
    end

    // Input pauses until the output has drained, then the output stalls long
    s_axis_tvalid <= 1'b0;
    wait (pink_q.size() == 0);
    @(negedge clk_i);
    hold_req = 1'b1;
    quiet    = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_white(16'($urandom), 1'b0, '0);
    end
    quiet = 1'b0;

    // Random segments
    done = 0;
    while (done < RANDOM_ITEMS) begin
      kind  = $urandom_range(0, 9);
      len   = $urandom_range(4, 40);
      quiet = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++) begin
        case (kind)
          5: begin
            white = 16'($urandom_range(24576, 32767));
          end
          6: begin
            white = 16'(-int'($urandom_range(24576, 32768)));
          end
          7: begin
            white = 16'(int'($urandom_range(0, 32)) - 16);
          end
          8: begin
            white = $urandom_range(0, 1) ? PINK_MAX : PINK_MIN;
          end
          default: begin
            white = 16'($urandom);
          end
        endcase
        send_white(white, 1'b0, '0);
        done = done + 1;
      end
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain
    wait (pink_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d white samples in, %0d pink samples checked", sent, checked);
    $display("tb: %0d results on the upper rail, %0d on the lower, one %0d-cycle stall",
             rail_hi, rail_lo, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
